FILE: hdl/line_segment_intersect_test_unit_assert.svh
// assertion macros for the line segment intersection unit
`ifndef LINE_SEGMENT_INTERSECT_TEST_UNIT_ASSERT_SVH
`define LINE_SEGMENT_INTERSECT_TEST_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk with rst_n low as disable
`define LSIT_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lsit assertion failed");

// next-cycle implication
`define LSIT_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lsit assertion failed");

`endif

FILE: hdl/lsit_pkg.sv
// constants and helpers for the line segment intersection unit
`default_nettype none

package lsit_pkg;

    localparam int OUT_W = 32;
    localparam int QUOT_TOP = OUT_W;
    localparam int OUT_TDATA_W = 4 * OUT_W;
    localparam int OUT_TUSER_W = 2;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7fffffff;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh80000000;

    // saturate an unsigned quotient magnitude with its sign to signed 32 bits
    function automatic logic signed [OUT_W-1:0] quot_sat(
        input logic [QUOT_TOP:0] q,
        input logic neg
    );
        logic signed [OUT_W-1:0] r;
        if (q[QUOT_TOP])
        begin
            r = neg ? OUT_MIN : OUT_MAX;
        end
        else if (!neg)
        begin
            r = q[OUT_W-1] ? OUT_MAX : $signed(q[OUT_W-1:0]);
        end
        else
        begin
            r = q[OUT_W-1] ? OUT_MIN : -$signed(q[OUT_W-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/line_segment_intersect_test_unit.sv
// line segment intersection test unit: two lines in, parameters, point and hit out
// pipeline from input beat to output beat: 4 setup stages, 33 divider stages,
// saturate, point multiply, point add; throughput: one beat per cycle unless
// the output stalls; the restoring divider is one quotient bit per stage
// a stalled output beat freezes the whole pipeline, so nothing is lost or repeated
// reset: rst_n asynchronous active low clears all valid bits, payload is not reset
`default_nettype none

module line_segment_intersect_test_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int DIR_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // a_origin_x, a_origin_y, a_dir_x, a_dir_y, a_upper, a_lower,
    // b_origin_x, b_origin_y, b_dir_x, b_dir_y, b_upper, b_lower
    input  wire logic [((8*COORD_WIDTH+4*DIR_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // a_param, b_param, cross_x, cross_y
    output logic [lsit_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit, parallel
    output logic [lsit_pkg::OUT_TUSER_W-1:0] m_tuser
);

    localparam int C = COORD_WIDTH;
    localparam int W = DIR_WIDTH;
    localparam int OW = lsit_pkg::OUT_W;
    localparam int QB = lsit_pkg::QUOT_TOP;
    localparam int FR = W - 2;
    localparam int RXW = C + 1;
    localparam int PW = RXW + W;
    localparam int NUMW = PW + 1;
    localparam int DW = 2 * W + 1;
    localparam int RW = (C + 2 * W > DW + QB) ? C + 2 * W : DW + QB;
    localparam int EW = (C > OW) ? C : OW;
    localparam int PXW = OW + W;
    localparam int SW = ((C > PXW) ? C : PXW) + 1;

    localparam int O_AOY = C;
    localparam int O_ADX = 2 * C;
    localparam int O_ADY = 2 * C + W;
    localparam int O_AUP = 2 * C + 2 * W;
    localparam int O_ALO = 3 * C + 2 * W;
    localparam int O_BOX = 4 * C + 2 * W;
    localparam int O_BOY = 5 * C + 2 * W;
    localparam int O_BDX = 6 * C + 2 * W;
    localparam int O_BDY = 6 * C + 3 * W;
    localparam int O_BUP = 6 * C + 4 * W;
    localparam int O_BLO = 7 * C + 4 * W;

    typedef struct packed {
        logic signed [C-1:0] aox;
        logic signed [C-1:0] aoy;
        logic signed [W-1:0] adx;
        logic signed [W-1:0] ady;
        logic signed [C-1:0] aup;
        logic signed [C-1:0] alo;
        logic signed [C-1:0] bup;
        logic signed [C-1:0] blo;
    } carry_t;

    typedef struct packed {
        logic [RW-1:0] rs;
        logic [RW-1:0] rt;
        logic [QB:0]   qs;
        logic [QB:0]   qt;
        logic          neg_s;
        logic          neg_t;
        logic          par;
        logic [DW-1:0] dm;
        carry_t        c;
    } div_t;

    logic en;
    logic v_out_reg;

    assign en = !v_out_reg || m_tready;
    assign s_tready = en;

    // stage 1: origin differences
    logic v1_reg;
    logic signed [RXW-1:0] rx1_reg, ry1_reg;
    logic signed [W-1:0] bdx1_reg, bdy1_reg;
    carry_t c1_reg;
    logic signed [C-1:0] in_aox, in_aoy, in_box, in_boy;

    assign in_aox = $signed(s_tdata[C-1:0]);
    assign in_aoy = $signed(s_tdata[O_AOY +: C]);
    assign in_box = $signed(s_tdata[O_BOX +: C]);
    assign in_boy = $signed(s_tdata[O_BOY +: C]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx1_reg <= RXW'(in_aox) - RXW'(in_box);
            ry1_reg <= RXW'(in_aoy) - RXW'(in_boy);
            bdx1_reg <= $signed(s_tdata[O_BDX +: W]);
            bdy1_reg <= $signed(s_tdata[O_BDY +: W]);
            c1_reg.aox <= in_aox;
            c1_reg.aoy <= in_aoy;
            c1_reg.adx <= $signed(s_tdata[O_ADX +: W]);
            c1_reg.ady <= $signed(s_tdata[O_ADY +: W]);
            c1_reg.aup <= $signed(s_tdata[O_AUP +: C]);
            c1_reg.alo <= $signed(s_tdata[O_ALO +: C]);
            c1_reg.bup <= $signed(s_tdata[O_BUP +: C]);
            c1_reg.blo <= $signed(s_tdata[O_BLO +: C]);
        end
    end

    // stage 2: cross products
    logic v2_reg;
    logic signed [PW-1:0] psy2_reg, psx2_reg, pty2_reg, ptx2_reg;
    logic signed [2*W-1:0] d12_reg, d22_reg;
    carry_t c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psy2_reg <= PW'(bdy1_reg) * PW'(rx1_reg);
            psx2_reg <= PW'(bdx1_reg) * PW'(ry1_reg);
            pty2_reg <= PW'(c1_reg.ady) * PW'(rx1_reg);
            ptx2_reg <= PW'(c1_reg.adx) * PW'(ry1_reg);
            d12_reg <= (2*W)'(bdx1_reg) * (2*W)'(c1_reg.ady);
            d22_reg <= (2*W)'(bdy1_reg) * (2*W)'(c1_reg.adx);
            c2_reg <= c1_reg;
        end
    end

    // stage 3: numerators and shared denominator
    logic v3_reg;
    logic signed [NUMW-1:0] ns3_reg, nt3_reg;
    logic signed [DW-1:0] den3_reg;
    carry_t c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ns3_reg <= NUMW'(psy2_reg) - NUMW'(psx2_reg);
            nt3_reg <= NUMW'(pty2_reg) - NUMW'(ptx2_reg);
            den3_reg <= DW'(d12_reg) - DW'(d22_reg);
            c3_reg <= c2_reg;
        end
    end

    // stage 4: magnitudes and signs feed the divider
    logic v4_reg;
    div_t pre_reg;
    logic [NUMW-1:0] ns_mag, nt_mag;
    logic [DW-1:0] den_mag;

    assign ns_mag = ns3_reg[NUMW-1] ? NUMW'(-ns3_reg) : NUMW'(ns3_reg);
    assign nt_mag = nt3_reg[NUMW-1] ? NUMW'(-nt3_reg) : NUMW'(nt3_reg);
    assign den_mag = den3_reg[DW-1] ? DW'(-den3_reg) : DW'(den3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg.rs <= RW'(ns_mag) << FR;
            pre_reg.rt <= RW'(nt_mag) << FR;
            pre_reg.qs <= '0;
            pre_reg.qt <= '0;
            pre_reg.neg_s <= ns3_reg[NUMW-1] ^ den3_reg[DW-1];
            pre_reg.neg_t <= nt3_reg[NUMW-1] ^ den3_reg[DW-1];
            pre_reg.par <= (den3_reg == '0);
            pre_reg.dm <= den_mag;
            pre_reg.c <= c3_reg;
        end
    end

    // restoring divider, one quotient bit per stage from bit QB down to 0;
    // the top bit only flags a quotient too large for the output
    logic v_div_reg [0:QB];
    div_t div_reg [0:QB];

    for (genvar gi = 0; gi <= QB; gi++)
    begin : g_div
        localparam int BIT = QB - gi;
        div_t src;
        logic src_v;
        div_t dst_next;
        logic [RW-1:0] dsh;

        if (gi == 0)
        begin : g_first
            assign src = pre_reg;
            assign src_v = v4_reg;
        end
        else
        begin : g_rest
            assign src = div_reg[gi-1];
            assign src_v = v_div_reg[gi-1];
        end

        assign dsh = RW'(src.dm) << BIT;

        always_comb
        begin
            dst_next = src;
            if (src.rs >= dsh)
            begin
                dst_next.rs = src.rs - dsh;
                dst_next.qs[BIT] = 1'b1;
            end
            if (src.rt >= dsh)
            begin
                dst_next.rt = src.rt - dsh;
                dst_next.qt[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_div_reg[gi] <= 1'b0;
            end
            else if (en)
            begin
                v_div_reg[gi] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[gi] <= dst_next;
            end
        end
    end

    // saturate quotients
    logic v_sat_reg;
    logic signed [OW-1:0] s_sat_reg, t_sat_reg;
    logic par_sat_reg;
    carry_t c_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_sat_reg <= 1'b0;
        end
        else if (en)
        begin
            v_sat_reg <= v_div_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_sat_reg <= lsit_pkg::quot_sat(div_reg[QB].qs, div_reg[QB].neg_s);
            t_sat_reg <= lsit_pkg::quot_sat(div_reg[QB].qt, div_reg[QB].neg_t);
            par_sat_reg <= div_reg[QB].par;
            c_sat_reg <= div_reg[QB].c;
        end
    end

    // point products and limit tests
    logic v_mul_reg;
    logic signed [PXW-1:0] px_mul_reg, py_mul_reg;
    logic signed [OW-1:0] s_mul_reg, t_mul_reg;
    logic signed [C-1:0] aox_mul_reg, aoy_mul_reg;
    logic hit_mul_reg, par_mul_reg;
    logic hit_next;

    assign hit_next = (EW'(s_sat_reg) < EW'(c_sat_reg.aup))
        && (EW'(s_sat_reg) > EW'(c_sat_reg.alo))
        && (EW'(t_sat_reg) < EW'(c_sat_reg.bup))
        && (EW'(t_sat_reg) > EW'(c_sat_reg.blo));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_mul_reg <= 1'b0;
        end
        else if (en)
        begin
            v_mul_reg <= v_sat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_mul_reg <= PXW'(s_sat_reg) * PXW'(c_sat_reg.adx);
            py_mul_reg <= PXW'(s_sat_reg) * PXW'(c_sat_reg.ady);
            s_mul_reg <= s_sat_reg;
            t_mul_reg <= t_sat_reg;
            aox_mul_reg <= c_sat_reg.aox;
            aoy_mul_reg <= c_sat_reg.aoy;
            hit_mul_reg <= hit_next;
            par_mul_reg <= par_sat_reg;
        end
    end

    // floor the products to q16.16, add origins, saturate
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [OW-1:0] cx_sat, cy_sat;
    logic signed [SW-1:0] smax, smin;

    assign smax = SW'(lsit_pkg::OUT_MAX);
    assign smin = SW'(lsit_pkg::OUT_MIN);
    assign sum_x = SW'(aox_mul_reg) + SW'(px_mul_reg >>> FR);
    assign sum_y = SW'(aoy_mul_reg) + SW'(py_mul_reg >>> FR);

    always_comb
    begin
        if (sum_x > smax)
        begin
            cx_sat = lsit_pkg::OUT_MAX;
        end
        else if (sum_x < smin)
        begin
            cx_sat = lsit_pkg::OUT_MIN;
        end
        else
        begin
            cx_sat = sum_x[OW-1:0];
        end
        if (sum_y > smax)
        begin
            cy_sat = lsit_pkg::OUT_MAX;
        end
        else if (sum_y < smin)
        begin
            cy_sat = lsit_pkg::OUT_MIN;
        end
        else
        begin
            cy_sat = sum_y[OW-1:0];
        end
    end

    logic [lsit_pkg::OUT_TDATA_W-1:0] tdata_out_reg;
    logic [lsit_pkg::OUT_TUSER_W-1:0] tuser_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out_reg <= 1'b0;
        end
        else if (en)
        begin
            v_out_reg <= v_mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (par_mul_reg)
            begin
                tdata_out_reg <= '0;
                tuser_out_reg <= 2'b10;
            end
            else
            begin
                tdata_out_reg <= {cy_sat, cx_sat, t_mul_reg, s_mul_reg};
                tuser_out_reg <= {1'b0, hit_mul_reg};
            end
        end
    end

    assign m_tvalid = v_out_reg;
    assign m_tdata = tdata_out_reg;
    assign m_tuser = tuser_out_reg;

`include "line_segment_intersect_test_unit_assert.svh"

    `LSIT_ASSERT_IMPL(a_par_zero, m_tvalid && m_tuser[1], (m_tdata == '0) && !m_tuser[0])
    `LSIT_ASSERT_IMPL(a_stall_blocks, m_tvalid && !m_tready, !s_tready)
    `LSIT_ASSERT_NEXT(a_ovf_sat, en && v_div_reg[QB] && div_reg[QB].qs[QB],
        (s_sat_reg == lsit_pkg::OUT_MAX) || (s_sat_reg == lsit_pkg::OUT_MIN))

endmodule

`default_nettype wire

FILE: dv/tb_line_segment_intersect_test_unit.sv
// testbench for the line segment intersection unit: streamed line pairs against a local predictor
`default_nettype none

module tb_line_segment_intersect_test_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W = 320;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic        hit;
        logic        par;
        logic [31:0] a_param;
        logic [31:0] b_param;
        logic [31:0] cross_x;
        logic [31:0] cross_y;
    } isect_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    // a_origin_x, a_origin_y, a_dir_x, a_dir_y, a_upper, a_lower,
    // b_origin_x, b_origin_y, b_dir_x, b_dir_y, b_upper, b_lower
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // a_param, b_param, cross_x, cross_y
    logic [lsit_pkg::OUT_TDATA_W-1:0] m_tdata;
    // hit, parallel
    logic [lsit_pkg::OUT_TUSER_W-1:0] m_tuser;

    logic [IN_W-1:0] line_pairs[$];
    isect_t expected_isect[$];
    int accepted_in;
    int mismatches;
    int idle_cycles;
    int hold_cycles;
    bit hold_done;
    bit in_beat;

    line_segment_intersect_test_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    function automatic logic [31:0] sat32(logic signed [127:0] v);
        logic [31:0] r;
        if (v > 128'sh7fffffff)
            r = 32'h7fffffff;
        else if (v < -128'sh80000000)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic isect_t predict_isect(logic [IN_W-1:0] d);
        logic signed [127:0] aox, aoy, adx, ady, aup, alo;
        logic signed [127:0] box, boy, bdx, bdy, bup, blo;
        logic signed [127:0] rx, ry, den, sv, tv, px, py;
        isect_t o;
        aox = $signed(d[31:0]);
        aoy = $signed(d[63:32]);
        adx = $signed(d[79:64]);
        ady = $signed(d[95:80]);
        aup = $signed(d[127:96]);
        alo = $signed(d[159:128]);
        box = $signed(d[191:160]);
        boy = $signed(d[223:192]);
        bdx = $signed(d[239:224]);
        bdy = $signed(d[255:240]);
        bup = $signed(d[287:256]);
        blo = $signed(d[319:288]);
        o = '0;
        rx = aox - box;
        ry = aoy - boy;
        den = bdx * ady - bdy * adx;
        if (den == 0)
        begin
            o.par = 1'b1;
            return o;
        end
        // signed division truncates toward zero
        o.a_param = sat32(((bdy * rx - bdx * ry) <<< 14) / den);
        o.b_param = sat32(((ady * rx - adx * ry) <<< 14) / den);
        sv = $signed(o.a_param);
        tv = $signed(o.b_param);
        // arithmetic shift floors the product
        px = (sv * adx) >>> 14;
        py = (sv * ady) >>> 14;
        o.cross_x = sat32(aox + px);
        o.cross_y = sat32(aoy + py);
        o.hit = sv < aup && sv > alo && tv < bup && tv > blo;
        return o;
    endfunction

    function automatic logic [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [15:0] rand_dir();
        int v;
        v = int'($urandom_range(0, 32768)) - 16384;
        return v[15:0];
    endfunction

    task automatic add_pair(logic [31:0] aox, logic [31:0] aoy, logic [15:0] adx,
                            logic [15:0] ady, logic [31:0] aup, logic [31:0] alo,
                            logic [31:0] box, logic [31:0] boy, logic [15:0] bdx,
                            logic [15:0] bdy, logic [31:0] bup, logic [31:0] blo);
        line_pairs.push_back({blo, bup, bdy, bdx, boy, box, alo, aup, ady, adx, aoy, aox});
    endtask

    task automatic add_random_pair();
        logic [31:0] c[8];
        logic [15:0] dx[2];
        logic [15:0] dy[2];
        int mode;
        mode = $urandom_range(0, 9);
        foreach (c[i])
            c[i] = rand_coord();
        dx[0] = rand_dir();
        dy[0] = rand_dir();
        dx[1] = rand_dir();
        dy[1] = rand_dir();
        if (mode == 0)
        begin
            // raw noise over every bit
            foreach (c[i])
                c[i] = $urandom;
            dx[0] = $urandom;
            dy[0] = $urandom;
            dx[1] = $urandom;
            dy[1] = $urandom;
        end
        else if (mode == 1)
        begin
            // parallel or antiparallel
            dx[1] = $urandom_range(0, 1) ? dx[0] : -dx[0];
            dy[1] = (dx[1] == dx[0]) ? dy[0] : -dy[0];
        end
        else if (mode >= 4)
        begin
            // limits bracketing zero so hits are common
            c[2] = {1'b0, c[2][30:0]} >> $urandom_range(0, 12);
            c[3] = -({1'b0, c[3][30:0]} >> $urandom_range(0, 12));
            c[6] = {1'b0, c[6][30:0]} >> $urandom_range(0, 12);
            c[7] = -({1'b0, c[7][30:0]} >> $urandom_range(0, 12));
        end
        add_pair(c[0], c[1], dx[0], dy[0], c[2], c[3], c[4], c[5], dx[1], dy[1], c[6], c[7]);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // directed cases
    initial
    begin
        // perpendicular through the origin, hit
        add_pair(32'hfffb0000, 0, 16'd16384, 0, 32'h000a0000, 0,
                 0, 32'hfffb0000, 0, 16'd16384, 32'h000a0000, 0);
        // same crossing with reversed limits, no hit
        add_pair(32'hfffb0000, 0, 16'd16384, 0, 0, 32'h000a0000,
                 0, 32'hfffb0000, 0, 16'd16384, 0, 32'h000a0000);
        // parallel lines
        add_pair(0, 0, 16'd11585, 16'd11585, 32'h7fffffff, 32'h80000000,
                 32'h00010000, 0, 16'd11585, 16'd11585, 32'h7fffffff, 32'h80000000);
        // antiparallel
        add_pair(0, 0, 16'd16384, 0, 32'h7fffffff, 32'h80000000,
                 0, 32'h00010000, -16'sd16384, 0, 32'h7fffffff, 32'h80000000);
        // zero direction
        add_pair(0, 0, 0, 0, 32'h7fffffff, 32'h80000000,
                 5, 7, 16'd16384, 16'd3, 32'h7fffffff, 32'h80000000);
        // extreme origins saturate the parameters
        add_pair(32'h7fffffff, 32'h7fffffff, 16'd16384, 16'd1, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h80000000, 16'd16384, 0, 32'h7fffffff, 32'h80000000);
        add_pair(32'h80000000, 32'h7fffffff, -16'sd16384, 16'd16384, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 16'd16384, 16'd16384,
                 32'h7fffffff, 32'h80000000);
        // out of range direction patterns
        add_pair(32'h00030000, 32'h00040000, 16'h8000, 16'h7fff, 32'h7fffffff, 32'h80000000,
                 0, 0, 16'h7fff, 16'h8000, 32'h7fffffff, 32'h80000000);
        add_pair(32'h12345678, 32'hedcba987, 16'hffff, 16'h0001, 32'h7fffffff, 32'h80000000,
                 32'h00000001, 32'hffffffff, 16'h0001, 16'h0001, 32'h7fffffff, 32'h80000000);
        // limits equal to the parameter, no hit on the boundary
        add_pair(32'hfffb0000, 0, 16'd16384, 0, 32'h00050000, 0,
                 0, 32'hfffb0000, 0, 16'd16384, 32'h00060000, 0);
        add_pair(32'hfffb0000, 0, 16'd16384, 0, 32'h00060000, 32'h00050000,
                 0, 32'hfffb0000, 0, 16'd16384, 32'h00060000, 32'h00040000);
        // negative parameters, rounding toward zero
        add_pair(32'h00000003, 32'h00000001, 16'd16384, 16'd3, 32'h7fffffff, 32'h80000000,
                 0, 0, 16'd7, -16'sd16384, 32'h7fffffff, 32'h80000000);
        add_pair(32'hffff0001, 32'h0000ffff, -16'sd11585, 16'd11585, 0, 32'h80000000,
                 32'h00010000, 32'hffff0000, 16'd11585, 16'd11585, 32'h7fffffff, 0);
        repeat (RANDOM_ITEMS)
            add_random_pair();
    end

    // driver
    always @(posedge clk)
        in_beat = s_tvalid && s_tready;

    always @(negedge clk)
    begin
        int sender_idle;
        sender_idle = (accepted_in < 500) ? 8 : (accepted_in < 1000) ? 83 : 0;
        if (rst_n && (in_beat || !s_tvalid))
        begin
            if (line_pairs.size() > 0 && $urandom_range(1, 100) > sender_idle)
            begin
                s_tdata <= line_pairs.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver with one long hold-off to back up the pipeline
    always @(negedge clk)
    begin
        int recv_idle;
        recv_idle = (accepted_in < 500) ? 83 : (accepted_in < 1000) ? 8 : 0;
        if (!hold_done && accepted_in >= 1200)
        begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
            m_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(1, 100) > recv_idle);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        isect_t got;
        isect_t want;
        bit any_beat;
        if (rst_n)
        begin
            any_beat = (s_tvalid && s_tready) || (m_tvalid && m_tready);
            if (any_beat)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready)
            begin
                expected_isect.push_back(predict_isect(s_tdata));
                accepted_in <= accepted_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tuser[1], m_tdata[31:0], m_tdata[63:32],
                       m_tdata[95:64], m_tdata[127:96]};
                if (expected_isect.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected beat: %h", got);
                end
                else
                begin
                    want = expected_isect.pop_front();
                    if (got !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: hit %b/%b par %b/%b s %h/%h t %h/%h x %h/%h y %h/%h",
                                     want.hit, got.hit, want.par, got.par,
                                     want.a_param, got.a_param, want.b_param, got.b_param,
                                     want.cross_x, got.cross_x, want.cross_y, got.cross_y);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        in_beat = 1'b0;
        accepted_in = 0;
        mismatches = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        hold_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (line_pairs.size() > 0 || s_tvalid || expected_isect.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_isect.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/lsit_pkg.sv
hdl/line_segment_intersect_test_unit.sv
dv/tb_line_segment_intersect_test_unit.sv
